/* design/three_axis_biquad_lowpass_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis biquad low-pass filter
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_BIQUAD_LOWPASS_ASSERT_SVH
`define THREE_AXIS_BIQUAD_LOWPASS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TABL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TABL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define TABL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tabl_pkg.sv */
// ----------------------------------------------------------------------------
// Three-axis biquad low-pass package
// Shared constants, coefficient type and register indexes.
// ----------------------------------------------------------------------------
package tabl_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int COEF_WIDTH         = 16;
    localparam int AXES               = 3;
    localparam int CFG_IDX_W          = 3;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] b0;
        logic signed [COEF_WIDTH-1:0] b1;
        logic signed [COEF_WIDTH-1:0] b2;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
    } t_coefs;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0 = 3'd0,
        CFG_B1 = 3'd1,
        CFG_B2 = 3'd2,
        CFG_A1 = 3'd3,
        CFG_A2 = 3'd4
    } t_cfg_idx;

    localparam logic signed [COEF_WIDTH-1:0] B0_RST = 16'sd3385;
    localparam logic signed [COEF_WIDTH-1:0] B1_RST = 16'sd6769;
    localparam logic signed [COEF_WIDTH-1:0] B2_RST = 16'sd3385;
    localparam logic signed [COEF_WIDTH-1:0] A1_RST = -16'sd6054;
    localparam logic signed [COEF_WIDTH-1:0] A2_RST = 16'sd3208;

endpackage

/* design/tabl_lane.sv */
// ----------------------------------------------------------------------------
// Biquad lane
// One axis of the direct form I section: history registers, products,
// rounding and saturation.
// ----------------------------------------------------------------------------
module tabl_lane #(
    parameter int SAMPLE_WIDTH   = tabl_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = tabl_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  tabl_pkg::t_coefs               i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_y
);
    import tabl_pkg::*;

    localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int AW = PW + 3;
    localparam logic signed [AW-1:0] ROUND = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] MAXV  = (AW'(1) << (SAMPLE_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] MINV  = ~MAXV;

    logic signed [SAMPLE_WIDTH-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [PW-1:0]           p0, p1, p2, p3, p4;
    logic signed [AW-1:0]           acc, shifted;
    logic signed [SAMPLE_WIDTH-1:0] y;

    always_comb begin
        p0      = i_coefs.b0 * i_x;
        p1      = i_coefs.b1 * r_x1;
        p2      = i_coefs.b2 * r_x2;
        p3      = i_coefs.a1 * r_y1;
        p4      = i_coefs.a2 * r_y2;
        acc     = AW'(p0) + AW'(p1) + AW'(p2) - AW'(p3) - AW'(p4) + ROUND;
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > MAXV) begin
            y = MAXV[SAMPLE_WIDTH-1:0];
        end else if (shifted < MINV) begin
            y = MINV[SAMPLE_WIDTH-1:0];
        end else begin
            y = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_en) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
            r_y1 <= y;
            r_y2 <= r_y1;
        end
    end

    assign o_y = y;

endmodule

/* design/tabl_outreg.sv */
// ----------------------------------------------------------------------------
// Result register
// Merges the three lane results into one output item and holds it while
// the downstream side stalls.
// ----------------------------------------------------------------------------
module tabl_outreg #(
    parameter int SAMPLE_WIDTH = tabl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y0,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y2,
    output logic                           o_in_stall,
    output logic                           o_accept,
    output logic                           o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_y0,
    output logic signed [SAMPLE_WIDTH-1:0] o_y1,
    output logic signed [SAMPLE_WIDTH-1:0] o_y2
);
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_y0, r_y1, r_y2;

    assign o_in_stall = r_valid & i_out_stall;
    assign o_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_accept) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_y0 <= i_y0;
            r_y1 <= i_y1;
            r_y2 <= i_y2;
        end
    end

    assign o_out_valid = r_valid;
    assign o_y0        = r_y0;
    assign o_y1        = r_y1;
    assign o_y2        = r_y2;

endmodule

/* design/three_axis_biquad_lowpass.sv */
// ----------------------------------------------------------------------------
// Three-axis biquad low-pass filter
// Roll, pitch and yaw rates each pass through a direct form I second-order
// section with shared Q2.14 coefficients, rounded and saturated.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_stall   roll, pitch, yaw rate in
//   output    out        o_out_valid / i_out_stall roll, pitch, yaw rate out
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle unless the output side stalls; the result is registered
// and appears in the cycle after its transfer. The limit is the combinational
// per-lane multiply, sum, round and saturate path closing the output feedback loop.
// Synchronous active-low reset clears histories and loads default coefficients.
// A held result stalls the input only while the output side stalls.
// ----------------------------------------------------------------------------
module three_axis_biquad_lowpass #(
    parameter int SAMPLE_WIDTH   = tabl_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = tabl_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_roll_rate_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_pitch_rate_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_yaw_rate_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_roll_rate_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_pitch_rate_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_yaw_rate_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tabl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [tabl_pkg::COEF_WIDTH-1:0] i_cfg_data
);
    import tabl_pkg::*;

    t_coefs                         r_coefs;
    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] x_in  [AXES];
    logic signed [SAMPLE_WIDTH-1:0] y_out [AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RST;
            r_coefs.b1 <= B1_RST;
            r_coefs.b2 <= B2_RST;
            r_coefs.a1 <= A1_RST;
            r_coefs.a2 <= A2_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_B0: r_coefs.b0 <= i_cfg_data;
                CFG_B1: r_coefs.b1 <= i_cfg_data;
                CFG_B2: r_coefs.b2 <= i_cfg_data;
                CFG_A1: r_coefs.a1 <= i_cfg_data;
                CFG_A2: r_coefs.a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign x_in[0] = i_roll_rate_in;
    assign x_in[1] = i_pitch_rate_in;
    assign x_in[2] = i_yaw_rate_in;

    for (genvar k = 0; k < AXES; k++) begin : g_lane
        tabl_lane #(
            .SAMPLE_WIDTH   (SAMPLE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (accept),
            .i_coefs (r_coefs),
            .i_x     (x_in[k]),
            .o_y     (y_out[k])
        );
    end

    tabl_outreg #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_y0        (y_out[0]),
        .i_y1        (y_out[1]),
        .i_y2        (y_out[2]),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .o_out_valid (o_out_valid),
        .o_y0        (o_roll_rate_out),
        .o_y1        (o_pitch_rate_out),
        .o_y2        (o_yaw_rate_out)
    );

endmodule

/* design/tabl_checker.sv */
// ----------------------------------------------------------------------------
// Three-axis biquad low-pass port checker
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`include "three_axis_biquad_lowpass_assert.svh"

module tabl_checker #(
    parameter int SAMPLE_WIDTH = tabl_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [SAMPLE_WIDTH-1:0] o_roll_rate_out,
    input logic [SAMPLE_WIDTH-1:0] o_pitch_rate_out,
    input logic [SAMPLE_WIDTH-1:0] o_yaw_rate_out
);

    `TABL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_roll_rate_out) && $stable(o_pitch_rate_out) && $stable(o_yaw_rate_out), "stalled result changed")

    `TABL_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a held result")

    `TABL_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid, "transfer gave no result")

    `TABL_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind three_axis_biquad_lowpass tabl_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tabl_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the three-axis biquad low-pass filter
// Drives roll, pitch and yaw rate samples through the filter under several
// coefficient settings and idle patterns, predicts every filtered rate with
// an independent direct form I model or a directed row, and compares each transfer.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tabl_pkg::*;

    localparam int SW              = SAMPLE_WIDTH_DEF;
    localparam int FRAC            = COEF_FRAC_BITS_DEF;
    localparam int ROLL            = 0;
    localparam int PITCH           = 1;
    localparam int YAW             = 2;
    localparam longint RATE_MAX    = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint RATE_MIN    = -(longint'(1) <<< (SW - 1));
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int PRESSURE_PHASE  = 4;
    localparam int LONG_HOLD       = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_NS      = 2_000_000;
    localparam int DIRECTED_ROWS   = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = CFG_IDX_W'(int'(CFG_A2) + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = '1;

    typedef struct packed {
        logic signed [SW-1:0] roll;
        logic signed [SW-1:0] pitch;
        logic signed [SW-1:0] yaw;
    } t_rates;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_COEF
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic signed [SW-1:0]   roll;
        logic signed [SW-1:0]   pitch;
        logic signed [SW-1:0]   yaw;
        logic                   chk;
        logic signed [SW-1:0]   want_roll;
        logic signed [SW-1:0]   want_pitch;
        logic signed [SW-1:0]   want_yaw;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic signed [SW-1:0]  i_roll_rate_in;
    logic signed [SW-1:0]  i_pitch_rate_in;
    logic signed [SW-1:0]  i_yaw_rate_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [SW-1:0]  o_roll_rate_out;
    logic signed [SW-1:0]  o_pitch_rate_out;
    logic signed [SW-1:0]  o_yaw_rate_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic signed [COEF_WIDTH-1:0] i_cfg_data;

    three_axis_biquad_lowpass dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_roll_rate_in   (i_roll_rate_in),
        .i_pitch_rate_in  (i_pitch_rate_in),
        .i_yaw_rate_in    (i_yaw_rate_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_roll_rate_out  (o_roll_rate_out),
        .o_pitch_rate_out (o_pitch_rate_out),
        .o_yaw_rate_out   (o_yaw_rate_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    t_coefs coef_model = '{B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
    logic signed [SW-1:0] x_prev1 [AXES] = '{default: '0};
    logic signed [SW-1:0] x_prev2 [AXES] = '{default: '0};
    logic signed [SW-1:0] y_prev1 [AXES] = '{default: '0};
    logic signed [SW-1:0] y_prev2 [AXES] = '{default: '0};

    t_rates pending_rates [$];
    t_rates row_expect;
    bit     row_expect_on;
    bit     long_hold_req;
    int     sender_idle_pct;
    int     receiver_stall_pct;

    int mismatches;
    int samples_accepted;
    int results_checked;
    int saturated_results;
    int coef_writes;
    int input_stall_cycles;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, '0,          0,      0,      0, 1'b1,      0,      0,      0},
        '{ROW_SAMPLE, '0,      32767, -32768,      1, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,     -32768,  32767,     -1, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,          0,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,      21845, -21846,   4660, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_B0,  16384,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_B1,      0,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_B2,      0,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_A1,      0,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_A2,      0,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,      32767, -32768,      0, 1'b1,  32767, -32768,      0},
        '{ROW_SAMPLE, '0,      21845, -21846,     -1, 1'b1,  21845, -21846,     -1},
        '{ROW_COEF,   CFG_SPARE_LO,  0,    0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_SPARE_TOP, 0,    0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,     -21846,  21845,      1, 1'b1, -21846,  21845,      1},
        '{ROW_COEF,   CFG_B0,   8192,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,          1,     -1,      3, 1'b1,      1,      0,      2},
        '{ROW_SAMPLE, '0,         -3,  32767, -32768, 1'b1,     -1,  16384, -16384},
        '{ROW_COEF,   CFG_B0,  32767,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,      32767, -32768,      0, 1'b1,  32767, -32768,      0},
        '{ROW_COEF,   CFG_B0, -32768,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,      32767, -32768,      0, 1'b1, -32768,  32767,      0},
        '{ROW_COEF,   CFG_B0,  16384,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_A1, -32768,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,       1000,  -1000,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,       1000,  -1000,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,          0,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_A2,  32767,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_B1, -32768,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_B2,  32767,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_COEF,   CFG_A1,  32767,      0,      0, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,      32767, -32768,     -1, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,     -32768,  32767,      1, 1'b0,      0,      0,      0},
        '{ROW_SAMPLE, '0,          0,      0,      0, 1'b0,      0,      0,      0}
    };

    function automatic logic signed [SW-1:0] filter_axis(input int k,
                                                         input logic signed [SW-1:0] x);
        longint acc;
        longint y;
        acc = longint'($signed(coef_model.b0)) * longint'(x)
            + longint'($signed(coef_model.b1)) * longint'(x_prev1[k])
            + longint'($signed(coef_model.b2)) * longint'(x_prev2[k])
            - longint'($signed(coef_model.a1)) * longint'(y_prev1[k])
            - longint'($signed(coef_model.a2)) * longint'(y_prev2[k]);
        acc = acc + (longint'(1) <<< (FRAC - 1));
        y = acc >>> FRAC;
        if (y > RATE_MAX) y = RATE_MAX;
        if (y < RATE_MIN) y = RATE_MIN;
        x_prev2[k] = x_prev1[k];
        x_prev1[k] = x;
        y_prev2[k] = y_prev1[k];
        y_prev1[k] = y[SW-1:0];
        return y[SW-1:0];
    endfunction

    function automatic t_rates filter_rates(input t_rates x);
        t_rates y;
        y.roll  = filter_axis(ROLL, x.roll);
        y.pitch = filter_axis(PITCH, x.pitch);
        y.yaw   = filter_axis(YAW, x.yaw);
        return y;
    endfunction

    function automatic void apply_coef_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic signed [COEF_WIDTH-1:0] val);
        case (idx)
            CFG_B0: coef_model.b0 = val;
            CFG_B1: coef_model.b1 = val;
            CFG_B2: coef_model.b2 = val;
            CFG_A1: coef_model.a1 = val;
            CFG_A2: coef_model.a2 = val;
            default: ;
        endcase
    endfunction

    function automatic logic signed [SW-1:0] rand_signed(input int lo, input int hi);
        int v;
        v = lo + int'($urandom_range(hi - lo));
        return v[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] rand_rate();
        logic signed [SW-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: v = RATE_MAX[SW-1:0];
                    1: v = RATE_MIN[SW-1:0];
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3: v = SW'($urandom());
            default: v = rand_signed(-2000, 2000);
        endcase
        return v;
    endfunction

    task automatic check_rate(input string axis, input logic signed [SW-1:0] want,
                              input logic signed [SW-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s rate mismatch, expected %0d, got %0d", $time, axis, want, got);
        end
    endtask

    task automatic send_rates(input t_rates r);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_roll_rate_in  <= r.roll;
        i_pitch_rate_in <= r.pitch;
        i_yaw_rate_in   <= r.yaw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_rates.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COEF_WIDTH-1:0] val, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(input t_coefs c);
        write_coef(CFG_B0, c.b0, 1'b0);
        write_coef(CFG_B1, c.b1, 1'b0);
        write_coef(CFG_B2, c.b2, 1'b0);
        write_coef(CFG_A1, c.a1, 1'b0);
        write_coef(CFG_A2, c.a2, 1'b1);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rates got;
        t_rates want;
        t_rates stim;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_roll_rate_out, o_pitch_rate_out, o_yaw_rate_out};
                if (pending_rates.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer, expected none, got %0d %0d %0d",
                             $time, got.roll, got.pitch, got.yaw);
                end else begin
                    want = pending_rates.pop_front();
                    check_rate("roll", want.roll, got.roll);
                    check_rate("pitch", want.pitch, got.pitch);
                    check_rate("yaw", want.yaw, got.yaw);
                    results_checked++;
                    if ($signed(got.roll) == RATE_MAX || $signed(got.roll) == RATE_MIN ||
                        $signed(got.pitch) == RATE_MAX || $signed(got.pitch) == RATE_MIN ||
                        $signed(got.yaw) == RATE_MAX || $signed(got.yaw) == RATE_MIN)
                        saturated_results++;
                end
            end
            if (i_in_valid && o_in_stall) input_stall_cycles++;
            if (i_in_valid && !o_in_stall) begin
                stim = '{i_roll_rate_in, i_pitch_rate_in, i_yaw_rate_in};
                want = filter_rates(stim);
                if (row_expect_on) want = row_expect;
                pending_rates.push_back(want);
                samples_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_coef_write(i_cfg_index, i_cfg_data);
                coef_writes++;
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("Timeout with %0d results outstanding", pending_rates.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_coefs coefs;
        t_stim_row r;
        bit last;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_roll_rate_in     = '0;
        i_pitch_rate_in    = '0;
        i_yaw_rate_in      = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        long_hold_req      = 1'b0;
        row_expect_on      = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            r = directed_rows[i];
            if (r.kind == ROW_COEF) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_COEF) drain_results();
                last = (i + 1 == DIRECTED_ROWS) || (directed_rows[i+1].kind != ROW_COEF);
                write_coef(r.idx, r.roll, last);
            end else begin
                row_expect_on = r.chk;
                row_expect    = '{r.want_roll, r.want_pitch, r.want_yaw};
                send_rates('{r.roll, r.pitch, r.yaw});
            end
        end
        row_expect_on = 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0: coefs = '{B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
                3: coefs = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
                5: coefs = '{default: 16'sh8000};
                2, 6: coefs = '{COEF_WIDTH'($urandom()), COEF_WIDTH'($urandom()),
                                COEF_WIDTH'($urandom()), COEF_WIDTH'($urandom()),
                                COEF_WIDTH'($urandom())};
                default: coefs = '{rand_signed(-8192, 8192), rand_signed(-8192, 8192),
                                   rand_signed(-8192, 8192), rand_signed(-24000, 24000),
                                   rand_signed(0, 12000)};
            endcase
            write_coef(CFG_IDX_W'($urandom_range(CFG_SPARE_TOP, CFG_SPARE_LO)),
                       COEF_WIDTH'($urandom()), 1'b0);
            load_coefs(coefs);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
                default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
            endcase
            if (phase == PRESSURE_PHASE) long_hold_req <= 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2) drain_results();
                send_rates('{rand_rate(), rand_rate(), rand_rate()});
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Filtered %0d rate samples into %0d checked results, %0d of them saturated,",
                 samples_accepted, results_checked, saturated_results);
        $display("with %0d coefficient writes and %0d cycles of input backpressure.",
                 coef_writes, input_stall_cycles);
        if (mismatches == 0 && pending_rates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
